[sv/gaussian_blur_5x5_rgb_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the Gaussian blur block
// Shared property forms, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GAUSSIAN_BLUR_5X5_RGB_DEFINES_SVH
`define GAUSSIAN_BLUR_5X5_RGB_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GB_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/gblur_pkg.sv]
// ----------------------------------------------------------------------------
// gblur_pkg
// Types, constants and kernel weight helpers of the streaming Gaussian blur.
// ----------------------------------------------------------------------------
`default_nettype none

package gblur_pkg;

	localparam int MAX_WIDTH_DEF        = 2048;
	localparam int KERNEL_SIZE_DEF      = 5;
	localparam int WEIGHT_FRAC_BITS_DEF = 16;

	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int PIX_W      = CH_W * NUM_CH;
	localparam int OUT_ROW_W  = 12;
	localparam int OUT_COL_W  = 11;
	localparam int IMG_W_W    = 12;
	localparam int IMG_H_W    = 13;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 13;

	localparam int MAX_HEIGHT     = 4096;
	localparam int EDGE_MARGIN    = 2;
	localparam int WIDTH_RESET    = 640;
	localparam int HEIGHT_RESET   = 480;
	localparam int RES_FIFO_DEPTH = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IMAGE_WIDTH  = 1'b0,
		CFG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0]      blue;
		logic [CH_W-1:0]      green;
		logic [CH_W-1:0]      red;
		logic [OUT_ROW_W-1:0] row;
		logic [OUT_COL_W-1:0] col;
		logic                 last;
	} res_t;

	// One-dimensional Gaussian profile for sigma 1.5, scaled by 2^16.
	function automatic longint unsigned gauss_1d(int d);
		longint unsigned g;
		case (d)
			0:       g = 64'd65536;
			1:       g = 64'd52477;
			2:       g = 64'd26943;
			3:       g = 64'd8869;
			default: g = 64'd1872;
		endcase
		return g;
	endfunction

	function automatic int tap_dist(int k, int i);
		int c;
		int d;
		c = k >> 1;
		d = (i > c) ? i - c : c - i;
		return (d > 4) ? 4 : d;
	endfunction

	function automatic longint unsigned kernel_prod(int k, int i, int j);
		return gauss_1d(tap_dist(k, i)) * gauss_1d(tap_dist(k, j));
	endfunction

	function automatic longint unsigned kernel_sum(int k);
		longint unsigned s;
		s = 64'd0;
		for (int i = 0; i < k; i++) begin
			for (int j = 0; j < k; j++) begin
				s += kernel_prod(k, i, j);
			end
		end
		return s;
	endfunction

endpackage

`default_nettype wire

[sv/gblur_pix_if.sv]
// ----------------------------------------------------------------------------
// gblur_pix_if
// Pixel request channel: valid/ready handshake with one RGB pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface gblur_pix_if;
	logic                        valid;
	logic                        ready;
	logic [gblur_pkg::CH_W-1:0] blue_in;
	logic [gblur_pkg::CH_W-1:0] green_in;
	logic [gblur_pkg::CH_W-1:0] red_in;

	modport source (output valid, output blue_in, output green_in, output red_in,
		input ready);
	modport sink (input valid, input blue_in, input green_in, input red_in,
		output ready);
endinterface

`default_nettype wire

[sv/gblur_res_if.sv]
// ----------------------------------------------------------------------------
// gblur_res_if
// Result request channel: one blurred pixel with its window coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

interface gblur_res_if;
	logic                             valid;
	logic                             ready;
	logic [gblur_pkg::CH_W-1:0]      blue_out;
	logic [gblur_pkg::CH_W-1:0]      green_out;
	logic [gblur_pkg::CH_W-1:0]      red_out;
	logic [gblur_pkg::OUT_ROW_W-1:0] out_row;
	logic [gblur_pkg::OUT_COL_W-1:0] out_col;
	logic                             frame_last;

	modport source (output valid, output blue_out, output green_out, output red_out,
		output out_row, output out_col, output frame_last, input ready);
	modport sink (input valid, input blue_out, input green_out, input red_out,
		input out_row, input out_col, input frame_last, output ready);
endinterface

`default_nettype wire

[sv/gaussian_blur_5x5_rgb.sv]
// Pipeline: an accepted pixel passes the line memory read, the window registers,
// the products and the row sums before its result is written to the result FIFO.
// Throughput: one pixel per cycle while pend_q is below the FIFO depth, set by
// the single line memory, with one read and one write of a column of line stores.
// Reset: arst_n clears the counters, pipeline valids and result FIFO; line memory
// contents stay undefined until written, with no clearing pass.
// ----------------------------------------------------------------------------
// gaussian_blur_5x5_rgb
// Streaming Gaussian blur over RGB pixels in raster order, emitting one result
// per full window off the last row and column, anchored at its top-left corner.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gaussian_blur_5x5_rgb_defines.svh"

module gaussian_blur_5x5_rgb #(
	parameter int MAX_WIDTH        = gblur_pkg::MAX_WIDTH_DEF,
	parameter int KERNEL_SIZE      = gblur_pkg::KERNEL_SIZE_DEF,
	parameter int WEIGHT_FRAC_BITS = gblur_pkg::WEIGHT_FRAC_BITS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [gblur_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  wire logic [gblur_pkg::CFG_DATA_W-1:0] cfg_wdata,
	gblur_pix_if.sink                             pix,
	gblur_res_if.source                           res
);

	localparam int LINES   = KERNEL_SIZE - 1;
	localparam int AW      = $clog2(MAX_WIDTH);
	localparam int SLOT_W  = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int PIX_W   = gblur_pkg::PIX_W;
	localparam int CH_W    = gblur_pkg::CH_W;
	localparam int NUM_CH  = gblur_pkg::NUM_CH;
	localparam int WORD_W  = LINES * PIX_W;
	localparam int WGT_W   = WEIGHT_FRAC_BITS + 1;
	localparam int PROD_W  = WGT_W + CH_W;
	localparam int RSUM_W  = PROD_W + $clog2(KERNEL_SIZE);
	localparam int ACC_W   = RSUM_W + $clog2(KERNEL_SIZE);
	localparam int FD      = gblur_pkg::RES_FIFO_DEPTH;
	localparam int PTR_W   = $clog2(FD);
	localparam int CNT_W   = $clog2(FD + 1);
	localparam int IMG_W_W = gblur_pkg::IMG_W_W;
	localparam int IMG_H_W = gblur_pkg::IMG_H_W;
	localparam int ROW_W   = gblur_pkg::OUT_ROW_W;
	localparam int COL_W   = gblur_pkg::OUT_COL_W;
	localparam longint unsigned KSUM = gblur_pkg::kernel_sum(KERNEL_SIZE);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [IMG_W_W-1:0] image_width_q;
	logic [IMG_H_W-1:0] image_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMG_W_W'(gblur_pkg::WIDTH_RESET);
			image_height_q <= IMG_H_W'(gblur_pkg::HEIGHT_RESET);
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				gblur_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[IMG_W_W-1:0];
				gblur_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata[IMG_H_W-1:0];
				default: ;
			endcase
		end
	end

	logic [IMG_W_W-1:0] w_eff;
	logic [IMG_H_W-1:0] h_eff;

	always_comb begin
		if (image_width_q < IMG_W_W'(KERNEL_SIZE + 1)) begin
			w_eff = IMG_W_W'(KERNEL_SIZE + 1);
		end else if (32'(image_width_q) > MAX_WIDTH) begin
			w_eff = IMG_W_W'(MAX_WIDTH);
		end else begin
			w_eff = image_width_q;
		end
		if (image_height_q < IMG_H_W'(KERNEL_SIZE + 1)) begin
			h_eff = IMG_H_W'(KERNEL_SIZE + 1);
		end else if (32'(image_height_q) > gblur_pkg::MAX_HEIGHT) begin
			h_eff = IMG_H_W'(gblur_pkg::MAX_HEIGHT);
		end else begin
			h_eff = image_height_q;
		end
	end

	// ------------------------------------------------------------------
	// Position counters and accept stage
	// ------------------------------------------------------------------
	logic [COL_W-1:0]  col_q, col_nx;
	logic [ROW_W-1:0]  row_q, row_nx;
	logic [SLOT_W-1:0] slot_q, slot_nx;
	logic [CNT_W-1:0]  pend_q;
	logic              in_fire;
	logic              out_fire;
	logic [COL_W-1:0]  x_cl;
	logic [AW-1:0]     rd_addr;
	logic              emit_acc;
	logic              last_acc;
	logic [IMG_W_W-1:0] col_inc;
	logic [IMG_H_W-1:0] row_inc;

	assign pix.ready = (pend_q < CNT_W'(FD));
	assign in_fire   = pix.valid && pix.ready;

	always_comb begin
		x_cl     = (32'(col_q) > MAX_WIDTH - 1) ? COL_W'(MAX_WIDTH - 1) : col_q;
		rd_addr  = AW'(x_cl);
		emit_acc = (row_q >= ROW_W'(LINES))
			&& ({1'b0, row_q} + IMG_H_W'(gblur_pkg::EDGE_MARGIN) <= h_eff)
			&& (x_cl >= COL_W'(LINES))
			&& ({1'b0, x_cl} + IMG_W_W'(gblur_pkg::EDGE_MARGIN) <= w_eff);
		last_acc = ({1'b0, row_q} + IMG_H_W'(gblur_pkg::EDGE_MARGIN) == h_eff)
			&& ({1'b0, x_cl} + IMG_W_W'(gblur_pkg::EDGE_MARGIN) == w_eff);

		col_inc = {1'b0, col_q} + IMG_W_W'(1);
		row_inc = {1'b0, row_q} + IMG_H_W'(1);
		col_nx  = col_inc[COL_W-1:0];
		row_nx  = row_q;
		slot_nx = slot_q;
		if (col_inc >= w_eff) begin
			col_nx = '0;
			if (row_inc >= h_eff) begin
				row_nx  = '0;
				slot_nx = '0;
			end else begin
				row_nx  = row_inc[ROW_W-1:0];
				slot_nx = (32'(slot_q) == LINES - 1) ? '0 : slot_q + SLOT_W'(1);
			end
		end else if ({1'b0, row_q} >= h_eff) begin
			row_nx  = '0;
			slot_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (in_fire) begin
			col_q  <= col_nx;
			row_q  <= row_nx;
			slot_q <= slot_nx;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: line memory read data and the write-back of the new column
	// ------------------------------------------------------------------
	logic                 v_s1;
	logic                 emit_s1;
	logic [PIX_W-1:0]     pix_s1;
	logic [AW-1:0]        addr_s1;
	logic [SLOT_W-1:0]    slot_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [COL_W-1:0]     col_s1;
	logic                 last_s1;
	logic [WORD_W-1:0]    rd_s1;
	logic [WORD_W-1:0]    wr_word;
	logic [PIX_W-1:0]     column [KERNEL_SIZE];
	logic [WORD_W-1:0]    line_mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_s1 <= line_mem[rd_addr];
		end
		if (v_s1) begin
			line_mem[addr_s1] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			v_s1    <= in_fire;
			emit_s1 <= in_fire && emit_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			pix_s1  <= {pix.red_in, pix.green_in, pix.blue_in};
			addr_s1 <= rd_addr;
			slot_s1 <= slot_q;
			row_s1  <= row_q - ROW_W'(LINES);
			col_s1  <= x_cl - COL_W'(LINES);
			last_s1 <= last_acc;
		end
	end

	// Line k of the window sits in physical slot (row + k) mod LINES; the slot
	// of the current row holds the oldest line and takes the new pixel.
	always_comb begin
		logic [SLOT_W:0] lane;
		wr_word = rd_s1;
		wr_word[32'(slot_s1) * PIX_W +: PIX_W] = pix_s1;
		for (int k = 0; k < LINES; k++) begin
			lane = {1'b0, slot_s1} + (SLOT_W + 1)'(k);
			if (32'(lane) >= LINES) begin
				lane = lane - (SLOT_W + 1)'(LINES);
			end
			column[k] = rd_s1[32'(lane[SLOT_W-1:0]) * PIX_W +: PIX_W];
		end
		column[LINES] = pix_s1;
	end

	// ------------------------------------------------------------------
	// Stage 2: window registers
	// ------------------------------------------------------------------
	logic [PIX_W-1:0] win_q [KERNEL_SIZE][KERNEL_SIZE];
	logic             emit_s2, emit_s3, emit_s4;
	logic [ROW_W-1:0] row_s2, row_s3, row_s4;
	logic [COL_W-1:0] col_s2, col_s3, col_s4;
	logic             last_s2, last_s3, last_s4;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
					win_q[r][c] <= win_q[r][c + 1];
				end
				win_q[r][KERNEL_SIZE - 1] <= column[r];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
			emit_s3 <= 1'b0;
			emit_s4 <= 1'b0;
		end else begin
			emit_s2 <= emit_s1;
			emit_s3 <= emit_s2;
			emit_s4 <= emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		row_s2  <= row_s1;
		col_s2  <= col_s1;
		last_s2 <= last_s1;
		row_s3  <= row_s2;
		col_s3  <= col_s2;
		last_s3 <= last_s2;
		row_s4  <= row_s3;
		col_s4  <= col_s3;
		last_s4 <= last_s3;
	end

	// ------------------------------------------------------------------
	// Stage 3: one constant-weight product per tap and channel
	// ------------------------------------------------------------------
	logic [PROD_W-1:0] prod_s3 [KERNEL_SIZE][KERNEL_SIZE][NUM_CH];

	for (genvar gi = 0; gi < KERNEL_SIZE; gi++) begin : g_row
		for (genvar gj = 0; gj < KERNEL_SIZE; gj++) begin : g_tap
			localparam longint unsigned WRAW =
				((gblur_pkg::kernel_prod(KERNEL_SIZE, gi, gj) << WEIGHT_FRAC_BITS)
				+ KSUM / 2) / KSUM;
			localparam logic [WGT_W-1:0] WGT = WGT_W'(WRAW);

			always_ff @(posedge clk) begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					prod_s3[gi][gj][ch] <= PROD_W'(WGT) * PROD_W'(win_q[gi][gj][ch * CH_W +: CH_W]);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: row sums; final sum, scaling and clamp feed the result FIFO
	// ------------------------------------------------------------------
	logic [RSUM_W-1:0] rsum_s4 [KERNEL_SIZE][NUM_CH];
	logic [ACC_W-1:0]  acc_sum;
	logic [ACC_W-1:0]  acc_scaled;
	logic [CH_W-1:0]   chan_out [NUM_CH];
	gblur_pkg::res_t   res_new;

	always_ff @(posedge clk) begin
		logic [RSUM_W-1:0] s;
		for (int r = 0; r < KERNEL_SIZE; r++) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				s = '0;
				for (int c = 0; c < KERNEL_SIZE; c++) begin
					s = s + RSUM_W'(prod_s3[r][c][ch]);
				end
				rsum_s4[r][ch] <= s;
			end
		end
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			acc_sum = '0;
			for (int r = 0; r < KERNEL_SIZE; r++) begin
				acc_sum = acc_sum + ACC_W'(rsum_s4[r][ch]);
			end
			acc_scaled = acc_sum >> WEIGHT_FRAC_BITS;
			chan_out[ch] = (acc_scaled > ACC_W'(255)) ? 8'hFF : acc_scaled[CH_W-1:0];
		end
		res_new.blue  = chan_out[0];
		res_new.green = chan_out[1];
		res_new.red   = chan_out[2];
		res_new.row   = row_s4;
		res_new.col   = col_s4;
		res_new.last  = last_s4;
	end

	// ------------------------------------------------------------------
	// Result FIFO; pend_q counts results in flight plus those queued, so a
	// new pixel is only taken while its result is sure to find room.
	// ------------------------------------------------------------------
	gblur_pkg::res_t  fifo_q [FD];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] fifo_cnt_q;
	gblur_pkg::res_t  res_head;

	assign res_head  = fifo_q[rp_q];
	assign res.valid = (fifo_cnt_q != '0);
	assign out_fire  = res.valid && res.ready;

	assign res.blue_out   = res_head.blue;
	assign res.green_out  = res_head.green;
	assign res.red_out    = res_head.red;
	assign res.out_row    = res_head.row;
	assign res.out_col    = res_head.col;
	assign res.frame_last = res_head.last;

	always_ff @(posedge clk) begin
		if (emit_s4) begin
			fifo_q[wp_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= '0;
			rp_q       <= '0;
			fifo_cnt_q <= '0;
			pend_q     <= '0;
		end else begin
			if (emit_s4) begin
				wp_q <= wp_q + PTR_W'(1);
			end
			if (out_fire) begin
				rp_q <= rp_q + PTR_W'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + CNT_W'(emit_s4) - CNT_W'(out_fire);
			pend_q     <= pend_q + CNT_W'(in_fire && emit_acc) - CNT_W'(out_fire);
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`GB_ASSERT_SAME(a_rmw_no_overlap, v_s1 && in_fire, addr_s1 != rd_addr,
		"line memory write-back and read hit the same column")
	`GB_ASSERT_SAME(a_fifo_room, emit_s4, fifo_cnt_q < CNT_W'(FD),
		"result arrived at a full FIFO")
	`GB_ASSERT_SAME(a_credit_cover, 1'b1, fifo_cnt_q <= pend_q,
		"queued results exceed outstanding credits")
	`GB_ASSERT_NEXT(a_credit_take, in_fire && emit_acc && !out_fire,
		pend_q == CNT_W'($past(pend_q) + CNT_W'(1)),
		"emitting request did not take a credit")

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming 5x5 RGB Gaussian blur. Frames, whole or
// cut short, go through the pixel channel with random gaps on both sides. A
// behavioral blur model predicts every windowed result, and a sink process
// compares each one field by field, in order.
// ----------------------------------------------------------------------------

module tb_top;

	localparam int          KSIZE        = 5;
	localparam int          NLINES       = KSIZE - 1;
	localparam int          MAXW         = 2048;
	localparam int          MAXH         = 4096;
	localparam int          FRAC         = 16;
	localparam int          DRAIN_CYC    = 12;
	localparam int          RANDOM_ITEMS = 550;
	localparam int unsigned RUN_LIMIT    = 3000000;

	typedef enum int {
		PAT_RANDOM,
		PAT_FULL,
		PAT_ZERO,
		PAT_EXTREME,
		PAT_CHECKER
	} pix_pattern_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [gblur_pkg::CFG_IDX_W-1:0]  cfg_addr;
	logic [gblur_pkg::CFG_DATA_W-1:0] cfg_wdata;

	gblur_pix_if pix_ch ();
	gblur_res_if res_ch ();

	gaussian_blur_5x5_rgb DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.pix       (pix_ch),
		.res       (res_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Blur model state.
	logic [11:0]       pred_width_reg  = 12'd640;
	logic [12:0]       pred_height_reg = 13'd480;
	logic [23:0]       line_mem [NLINES*MAXW];
	logic [23:0]       blur_win [KSIZE][KSIZE];
	int unsigned       pred_col;
	int unsigned       pred_row;
	longint unsigned   kern_w [KSIZE][KSIZE];
	gblur_pkg::res_t   blur_q [$];

	int unsigned pix_count;
	int unsigned mismatches;
	bit          src_burst;
	bit          sink_burst;
	int unsigned hold_len;

	function automatic longint unsigned profile(int d);
		longint unsigned g;
		case (d)
			0:       g = 65536;
			1:       g = 52477;
			2:       g = 26943;
			3:       g = 8869;
			default: g = 1872;
		endcase
		return g;
	endfunction

	function automatic void build_kernel();
		longint unsigned total;
		longint unsigned p;
		int di;
		int dj;
		total = 0;
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE; j++) begin
				di = (i > KSIZE / 2) ? i - KSIZE / 2 : KSIZE / 2 - i;
				dj = (j > KSIZE / 2) ? j - KSIZE / 2 : KSIZE / 2 - j;
				total += profile(di) * profile(dj);
			end
		end
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE; j++) begin
				di = (i > KSIZE / 2) ? i - KSIZE / 2 : KSIZE / 2 - i;
				dj = (j > KSIZE / 2) ? j - KSIZE / 2 : KSIZE / 2 - j;
				p = profile(di) * profile(dj);
				kern_w[i][j] = ((p << FRAC) + total / 2) / total;
			end
		end
	endfunction

	function automatic int unsigned eff_width();
		int unsigned v;
		v = 32'(pred_width_reg);
		if (v < KSIZE + 1) v = KSIZE + 1;
		if (v > MAXW) v = MAXW;
		return v;
	endfunction

	function automatic int unsigned eff_height();
		int unsigned v;
		v = 32'(pred_height_reg);
		if (v < KSIZE + 1) v = KSIZE + 1;
		if (v > MAXH) v = MAXH;
		return v;
	endfunction

	function automatic logic [7:0] blur_channel(int sh);
		longint unsigned acc;
		longint unsigned v;
		acc = 0;
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE; j++) begin
				acc += kern_w[i][j] * 64'((blur_win[i][j] >> sh) & 24'hFF);
			end
		end
		v = acc >> FRAC;
		return (v > 255) ? 8'hFF : 8'(v);
	endfunction

	// Advances the model by one accepted pixel and queues any result it produces.
	function automatic void predict_blur(input logic [7:0] b, input logic [7:0] g,
		input logic [7:0] r);
		int unsigned w;
		int unsigned h;
		int unsigned x;
		int unsigned y;
		logic [23:0] column [KSIZE];
		gblur_pkg::res_t e;
		w = eff_width();
		h = eff_height();
		x = pred_col;
		y = pred_row;
		if (x >= MAXW) x = MAXW - 1;
		for (int k = 0; k < NLINES; k++) begin
			column[k] = line_mem[((y + k) % NLINES) * MAXW + x];
		end
		column[NLINES] = {r, g, b};
		line_mem[(y % NLINES) * MAXW + x] = {r, g, b};
		for (int rr = 0; rr < KSIZE; rr++) begin
			for (int cc = 0; cc < KSIZE - 1; cc++) begin
				blur_win[rr][cc] = blur_win[rr][cc + 1];
			end
			blur_win[rr][KSIZE - 1] = column[rr];
		end
		if (y >= NLINES && y + 2 <= h && x >= NLINES && x + 2 <= w) begin
			e.blue  = blur_channel(0);
			e.green = blur_channel(8);
			e.red   = blur_channel(16);
			e.row   = 12'(y - NLINES);
			e.col   = 11'(x - NLINES);
			e.last  = (y + 2 == h) && (x + 2 == w);
			blur_q = {blur_q, e};
		end
		pred_col = pred_col + 1;
		if (pred_col >= w) begin
			pred_col = 0;
			pred_row = pred_row + 1;
			if (pred_row >= h) pred_row = 0;
		end else if (pred_row >= h) begin
			pred_row = 0;
		end
		pred_col &= 32'h7FF;
		pred_row &= 32'hFFF;
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
		int unsigned gap;
		gap = src_burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid    <= 1'b1;
		pix_ch.blue_in  <= b;
		pix_ch.green_in <= g;
		pix_ch.red_in   <= r;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		predict_blur(b, g, r);
		pix_count++;
	endtask

	// A nonzero row count sends only the first rows of the frame.
	task automatic send_frame(input pix_pattern_t pat, input int unsigned rows = 0);
		int unsigned w;
		int unsigned h;
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		w = eff_width();
		h = (rows != 0) ? rows : eff_height();
		for (int unsigned y = 0; y < h; y++) begin
			for (int unsigned x = 0; x < w; x++) begin
				case (pat)
					PAT_FULL: begin
						b = 8'hFF;
						g = 8'hFF;
						r = 8'hFF;
					end
					PAT_ZERO: begin
						b = 8'h00;
						g = 8'h00;
						r = 8'h00;
					end
					PAT_EXTREME: begin
						b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
						g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
						r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					end
					PAT_CHECKER: begin
						b = ((x ^ y) & 1) ? 8'hFF : 8'h00;
						g = ~b;
						r = 8'(x * 37 + y * 11);
					end
					default: begin
						b = 8'($urandom_range(0, 255));
						g = 8'($urandom_range(0, 255));
						r = 8'($urandom_range(0, 255));
					end
				endcase
				send_pixel(b, g, r);
			end
		end
	endtask

	// Trailing pixels of a frame produce no result, so a few extra cycles let
	// them leave the pipeline before anything is reconfigured.
	task automatic drain_and_idle();
		pix_ch.valid <= 1'b0;
		while (blur_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	task automatic write_reg(input gblur_pkg::cfg_reg_t idx, input logic [12:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == gblur_pkg::CFG_IMAGE_WIDTH) pred_width_reg = value[11:0];
		else pred_height_reg = value;
	endtask

	task automatic set_frame_size(input logic [12:0] w_val, input logic [12:0] h_val);
		drain_and_idle();
		write_reg(gblur_pkg::CFG_IMAGE_WIDTH, w_val);
		write_reg(gblur_pkg::CFG_IMAGE_HEIGHT, h_val);
	endtask

	// Smallest legal frame: one window each, saturated and then high contrast.
	task automatic test_small_frames();
		set_frame_size(13'd6, 13'd6);
		send_frame(PAT_FULL);
		send_frame(PAT_CHECKER);
	endtask

	// Sizes below the minimum clamp up; bit 12 of the width write is dropped.
	task automatic test_low_clamp();
		set_frame_size(13'h1000, 13'd0);
		send_frame(PAT_EXTREME);
	endtask

	// Wide rows sent back to back, from a width write whose bit 12 is dropped.
	task automatic test_wide_frame();
		set_frame_size(13'h1064, 13'd6);
		src_burst = 1'b1;
		send_frame(PAT_RANDOM);
		src_burst = 1'b0;
	endtask

	// An all-ones height write clamps to the tallest frame. Only its first rows
	// are sent, so none of the results carries the last flag.
	task automatic test_tall_frame();
		set_frame_size(13'd3, 13'h1FFF);
		src_burst = 1'b1;
		send_frame(PAT_RANDOM, 10);
		src_burst = 1'b0;
	endtask

	// The sink holds off long enough for the result buffer to fill and the
	// pixel channel to stall while the source keeps a request pending.
	task automatic test_stall_pressure();
		set_frame_size(13'd40, 13'd10);
		src_burst  = 1'b1;
		sink_burst = 1'b0;
		hold_len   = 400;
		send_frame(PAT_RANDOM);
		src_burst = 1'b0;
	endtask

	task automatic test_random_frames();
		int unsigned start;
		int unsigned sel;
		int unsigned wv;
		int unsigned hv;
		pix_pattern_t pat;
		start = pix_count;
		while (pix_count - start < RANDOM_ITEMS) begin
			// Frames that keep the size run back to back without a drain.
			if ($urandom_range(0, 2) != 0) begin
				sel = $urandom_range(0, 19);
				if (sel < 15) wv = $urandom_range(6, 16);
				else if (sel < 19) wv = $urandom_range(17, 64);
				else wv = $urandom_range(0, 5);
				wv |= $urandom_range(0, 1) << 12;
				sel = $urandom_range(0, 19);
				if (sel < 18) hv = $urandom_range(6, 12);
				else hv = $urandom_range(0, 5);
				set_frame_size(13'(wv), 13'(hv));
			end
			src_burst  = ($urandom_range(0, 4) == 0);
			sink_burst = ($urandom_range(0, 4) == 0);
			sel = $urandom_range(0, 9);
			case (sel)
				0:       pat = PAT_FULL;
				1:       pat = PAT_ZERO;
				2, 3:    pat = PAT_EXTREME;
				default: pat = PAT_RANDOM;
			endcase
			send_frame(pat);
		end
		src_burst  = 1'b0;
		sink_burst = 1'b0;
	endtask

	initial begin : test_sequence
		arst_n          <= 1'b0;
		cfg_wr_en       <= 1'b0;
		cfg_addr        <= gblur_pkg::CFG_IMAGE_WIDTH;
		cfg_wdata       <= '0;
		pix_ch.valid    <= 1'b0;
		pix_ch.blue_in  <= '0;
		pix_ch.green_in <= '0;
		pix_ch.red_in   <= '0;
		pred_col   = 0;
		pred_row   = 0;
		pix_count  = 0;
		mismatches = 0;
		src_burst  = 1'b0;
		sink_burst = 1'b0;
		hold_len   = 0;
		for (int i = 0; i < KSIZE; i++) begin
			for (int j = 0; j < KSIZE; j++) begin
				blur_win[i][j] = '0;
			end
		end
		build_kernel();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_frames();
		test_low_clamp();
		test_random_frames();
		test_stall_pressure();
		test_wide_frame();
		test_tall_frame();

		drain_and_idle();
		if (mismatches == 0) begin
			$display("gaussian_blur_5x5_rgb: match");
		end else begin
			$display("gaussian_blur_5x5_rgb: mismatch");
		end
		$finish;
	end

	initial begin : result_sink
		int unsigned wait_cyc;
		gblur_pkg::res_t want;
		res_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			wait_cyc = sink_burst ? 0 : $urandom_range(0, 13);
			wait_cyc += hold_len;
			hold_len = 0;
			if (wait_cyc > 0) begin
				res_ch.ready <= 1'b0;
				repeat (wait_cyc) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			@(posedge clk);
			while (!res_ch.valid) @(posedge clk);
			if (blur_q.size() == 0) begin
				$error("unexpected result at row %0d col %0d", res_ch.out_row, res_ch.out_col);
				mismatches++;
			end else begin
				want = blur_q.pop_front();
				check_field("blue_out", 16'(want.blue), 16'(res_ch.blue_out));
				check_field("green_out", 16'(want.green), 16'(res_ch.green_out));
				check_field("red_out", 16'(want.red), 16'(res_ch.red_out));
				check_field("out_row", 16'(want.row), 16'(res_ch.out_row));
				check_field("out_col", 16'(want.col), 16'(res_ch.out_col));
				check_field("frame_last", 16'(want.last), 16'(res_ch.frame_last));
			end
		end
	end

	initial begin : watchdog
		int unsigned cyc;
		cyc = 0;
		while (cyc < RUN_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("gaussian_blur_5x5_rgb: mismatch");
		$finish;
	end

endmodule
